@@ sv/bkpf_pkg.sv @@
// ----------------------------------------------------------------------------
// bkpf_pkg
// Shared types and constants of the braille key packet framer.
// ----------------------------------------------------------------------------
package bkpf_pkg;

    // packet framing bytes
    localparam logic [7:0] KEY_NAV   = 8'h13;
    localparam logic [7:0] KEY_SIM   = 8'hFE;
    localparam logic [7:0] KEY_ROUTE = 8'hFF;
    localparam logic [7:0] KEY_END   = 8'h19;
    localparam logic [7:0] IDENT_P   = 8'h50;
    localparam logic [7:0] IDENT_B   = 8'h42;
    localparam logic [7:0] IDENT_C   = 8'h43;
    localparam logic [7:0] IDENT_END = 8'h40;

    localparam logic [5:0] KEY_LEN   = 6'd4;
    localparam logic [5:0] IDENT_MAX = 6'd44;
    localparam logic [5:0] IDENT_HDR = 6'd3;

    typedef enum logic [1:0] {
        GRP_IDLE  = 2'd0,
        GRP_KEY   = 2'd1,
        GRP_IDENT = 2'd2
    } group_t;

    typedef enum logic [2:0] {
        EV_STORED        = 3'd0,
        EV_DONE          = 3'd1,
        EV_IGNORED       = 3'd2,
        EV_SHORT_RESTART = 3'd3,
        EV_SHORT_IGNORED = 3'd4,
        EV_TIMEOUT       = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        KIND_NAV   = 2'd0,
        KIND_SIM   = 2'd1,
        KIND_ROUTE = 2'd2,
        KIND_IDENT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       gap;
    } byte_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] packet_kind;
        logic [7:0] byte_value;
        logic [5:0] byte_index;
        logic [7:0] key_value;
        logic [5:0] packet_length;
    } result_item_t;

    // key kind from the opening byte of a key packet
    function automatic kind_t key_kind(input logic [7:0] b);
        kind_t k;
        if (b == KEY_NAV)
        begin
            k = KIND_NAV;
        end
        else if (b == KEY_SIM)
        begin
            k = KIND_SIM;
        end
        else
        begin
            k = KIND_ROUTE;
        end
        return k;
    endfunction

endpackage

@@ sv/bkpf_stream_if.sv @@
// ----------------------------------------------------------------------------
// bkpf_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bkpf_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/braille_key_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// braille_key_packet_framer_top
// Frames received display bytes into key and identity packets, one result
// item per received byte or read timeout.
// ----------------------------------------------------------------------------
// Takes one item per clock when the result side keeps up: an item is caught
// in the input register, decoded against the framer state combinationally and
// written to the result register once that register is free, where the result
// is offered to the sink until it is taken.
// The framer state is updated in the same edge that moves
// an item from the input register to the result register, so the next item
// always sees it. A result waiting on a stalled sink holds the result
// register while one more item may still be taken into the input register.
module braille_key_packet_framer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    bkpf_stream_if.sink          byte_ch,
    bkpf_stream_if.source        result_ch
);

    logic                   in_valid_reg;
    bkpf_pkg::byte_item_t   in_item_reg;
    logic                   out_valid_reg;
    bkpf_pkg::result_item_t out_item_reg;

    bkpf_pkg::group_t       group_reg, group_next;
    logic [5:0]             pos_reg, pos_next;
    logic [7:0]             first_byte_reg, first_byte_next;
    logic [7:0]             held_key_reg, held_key_next;

    logic                   advance;
    logic [7:0]             b;
    logic                   is_key_start, is_ident_start, start_ok;
    logic                   fresh, bad, restart;
    logic [5:0]             idx, next_pos;
    logic                   ident_at_end, done;
    bkpf_pkg::kind_t        start_kind, cur_kind;
    bkpf_pkg::result_item_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = out_item_reg;

    assign b              = in_item_reg.data_byte;
    assign is_key_start   = (b == bkpf_pkg::KEY_NAV) || (b == bkpf_pkg::KEY_SIM)
                            || (b == bkpf_pkg::KEY_ROUTE);
    assign is_ident_start = (b == bkpf_pkg::IDENT_P);
    assign start_ok       = is_key_start || is_ident_start;
    assign fresh          = (pos_reg == 6'd0);

    // does this byte break the packet in progress
    always_comb
    begin
        bad = 1'b0;
        if (!fresh)
        begin
            unique case (group_reg)
                bkpf_pkg::GRP_IDENT:
                begin
                    if (pos_reg < bkpf_pkg::IDENT_HDR)
                    begin
                        bad = (pos_reg == 6'd1) ? (b != bkpf_pkg::IDENT_B)
                                                : (b != bkpf_pkg::IDENT_C);
                    end
                end
                bkpf_pkg::GRP_KEY:
                begin
                    bad = ((pos_reg == 6'd1) && (b != first_byte_reg))
                          || ((pos_reg == 6'd3) && (b != bkpf_pkg::KEY_END));
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
        end
    end

    assign restart    = fresh || bad;
    assign start_kind = is_ident_start ? bkpf_pkg::KIND_IDENT : bkpf_pkg::key_kind(b);
    assign cur_kind   = (group_reg == bkpf_pkg::GRP_IDENT) ? bkpf_pkg::KIND_IDENT
                                                           : bkpf_pkg::key_kind(first_byte_reg);
    assign idx        = restart ? 6'd0 : pos_reg;
    assign next_pos   = idx + 6'd1;

    assign ident_at_end = !restart && (group_reg == bkpf_pkg::GRP_IDENT)
                          && (pos_reg >= bkpf_pkg::IDENT_HDR) && (b == bkpf_pkg::IDENT_END);
    assign done = !restart
                  && (((group_reg == bkpf_pkg::GRP_KEY) && (next_pos == bkpf_pkg::KEY_LEN))
                      || ((group_reg == bkpf_pkg::GRP_IDENT)
                          && (ident_at_end || (next_pos == bkpf_pkg::IDENT_MAX))));

    // result item and next framer state
    always_comb
    begin
        group_next      = group_reg;
        pos_next        = pos_reg;
        first_byte_next = first_byte_reg;
        held_key_next   = held_key_reg;
        res             = '0;
        res.byte_value  = b;

        priority if (in_item_reg.gap)
        begin
            res.event_res     = bkpf_pkg::EV_TIMEOUT;
            res.byte_value    = 8'd0;
            res.packet_length = pos_reg;
            group_next        = bkpf_pkg::GRP_IDLE;
            pos_next          = 6'd0;
        end
        else if (restart && !start_ok)
        begin
            res.event_res     = bad ? bkpf_pkg::EV_SHORT_IGNORED : bkpf_pkg::EV_IGNORED;
            res.packet_length = bad ? pos_reg : 6'd0;
            group_next        = bkpf_pkg::GRP_IDLE;
            pos_next          = 6'd0;
        end
        else
        begin
            res.packet_kind = restart ? start_kind : cur_kind;
            res.byte_index  = idx;
            pos_next        = next_pos;
            if (restart)
            begin
                group_next        = is_ident_start ? bkpf_pkg::GRP_IDENT : bkpf_pkg::GRP_KEY;
                first_byte_next   = b;
                held_key_next     = 8'd0;
                res.event_res     = bad ? bkpf_pkg::EV_SHORT_RESTART : bkpf_pkg::EV_STORED;
                res.packet_length = bad ? pos_reg : 6'd0;
            end
            else
            begin
                res.event_res = bkpf_pkg::EV_STORED;
                if ((group_reg == bkpf_pkg::GRP_KEY) && (pos_reg == 6'd2))
                begin
                    held_key_next = b;
                end
            end
            if (done)
            begin
                res.event_res     = bkpf_pkg::EV_DONE;
                res.packet_length = next_pos;
                res.key_value     = (group_reg == bkpf_pkg::GRP_KEY) ? held_key_reg : 8'd0;
                group_next        = bkpf_pkg::GRP_IDLE;
                pos_next          = 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            group_reg      <= bkpf_pkg::GRP_IDLE;
            pos_reg        <= 6'd0;
            first_byte_reg <= 8'd0;
            held_key_reg   <= 8'd0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                group_reg      <= group_next;
                pos_reg        <= pos_next;
                first_byte_reg <= first_byte_next;
                held_key_reg   <= held_key_next;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_item_reg <= byte_ch.payload;
        end
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    // idle framer has no position, an open packet always has one
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == 6'd0) == (group_reg == bkpf_pkg::GRP_IDLE))
    else $error("framer position and group disagree");

    // an open identity packet never reaches its length limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < bkpf_pkg::IDENT_MAX)
    else $error("framer position past identity limit");

    // a finished key packet is always four bytes long
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.event_res == bkpf_pkg::EV_DONE)
         && (out_item_reg.packet_kind != bkpf_pkg::KIND_IDENT))
        |-> (out_item_reg.packet_length == bkpf_pkg::KEY_LEN))
    else $error("key packet done with wrong length");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bytes and read timeouts into the packet framer, predicts every
// result item from its own copy of the framing state and checks each field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 385;

    class framer_scoreboard;
        bkpf_pkg::group_t       grp;
        logic [5:0]             pos;
        logic [5:0]             pkt_len;
        logic [7:0]             opener;
        logic [7:0]             held;
        bkpf_pkg::result_item_t framed_results[$];
        int                     errors;

        function new();
            grp = bkpf_pkg::GRP_IDLE;
            pos = '0;
            pkt_len = 6'd1;
            opener = '0;
            held = '0;
            errors = 0;
        endfunction

        function void drop_packet();
            grp = bkpf_pkg::GRP_IDLE;
            pos = '0;
            pkt_len = 6'd1;
        endfunction

        // opens a packet on b, returns 0 when b cannot start one
        function bit open_packet(logic [7:0] b);
            if (b == bkpf_pkg::KEY_NAV || b == bkpf_pkg::KEY_SIM || b == bkpf_pkg::KEY_ROUTE)
            begin
                grp = bkpf_pkg::GRP_KEY;
                pkt_len = bkpf_pkg::KEY_LEN;
            end
            else if (b == bkpf_pkg::IDENT_P)
            begin
                grp = bkpf_pkg::GRP_IDENT;
                pkt_len = bkpf_pkg::IDENT_MAX;
            end
            else
            begin
                return 1'b0;
            end
            opener = b;
            held = '0;
            return 1'b1;
        endfunction

        function bkpf_pkg::result_item_t frame_byte(logic [7:0] b, logic gap);
            bkpf_pkg::result_item_t r;
            bit fresh;
            bit broken;
            r = '0;
            r.byte_value = b;
            if (gap)
            begin
                r.event_res = bkpf_pkg::EV_TIMEOUT;
                r.packet_length = pos;
                r.byte_value = '0;
                drop_packet();
                return r;
            end
            fresh = (pos == 0);
            broken = 1'b0;
            if (!fresh)
            begin
                if (grp == bkpf_pkg::GRP_IDENT)
                begin
                    if (pos == 6'd1)
                        broken = (b != bkpf_pkg::IDENT_B);
                    else if (pos == 6'd2)
                        broken = (b != bkpf_pkg::IDENT_C);
                    else if (b == bkpf_pkg::IDENT_END)
                        pkt_len = pos + 6'd1;
                end
                else if (grp == bkpf_pkg::GRP_KEY)
                begin
                    if (pos == 6'd1 && b != opener)
                        broken = 1'b1;
                    else if (pos == 6'd3 && b != bkpf_pkg::KEY_END)
                        broken = 1'b1;
                end
                else
                begin
                    broken = 1'b1;
                end
            end
            if (broken)
            begin
                r.packet_length = pos;
                drop_packet();
            end
            r.event_res = bkpf_pkg::EV_STORED;
            if (fresh || broken)
            begin
                // the breaking byte gets a second chance as a packet start
                if (!open_packet(b))
                begin
                    r.event_res = broken ? bkpf_pkg::EV_SHORT_IGNORED : bkpf_pkg::EV_IGNORED;
                    return r;
                end
                if (broken)
                    r.event_res = bkpf_pkg::EV_SHORT_RESTART;
            end
            if (grp == bkpf_pkg::GRP_IDENT)
                r.packet_kind = bkpf_pkg::KIND_IDENT;
            else if (opener == bkpf_pkg::KEY_NAV)
                r.packet_kind = bkpf_pkg::KIND_NAV;
            else if (opener == bkpf_pkg::KEY_SIM)
                r.packet_kind = bkpf_pkg::KIND_SIM;
            else
                r.packet_kind = bkpf_pkg::KIND_ROUTE;
            r.byte_index = pos;
            if (grp == bkpf_pkg::GRP_KEY && pos == 6'd2)
                held = b;
            pos = pos + 6'd1;
            if (pos >= pkt_len)
            begin
                r.event_res = bkpf_pkg::EV_DONE;
                r.packet_length = pkt_len;
                if (grp == bkpf_pkg::GRP_KEY)
                    r.key_value = held;
                drop_packet();
            end
            return r;
        endfunction

        function void note_byte(bkpf_pkg::byte_item_t it);
            framed_results.push_back(frame_byte(it.data_byte, it.gap));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(bkpf_pkg::result_item_t got);
            bkpf_pkg::result_item_t want;
            if (framed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = framed_results.pop_front();
            compare_field("event_res", 8'(want.event_res), 8'(got.event_res));
            compare_field("packet_kind", 8'(want.packet_kind), 8'(got.packet_kind));
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
            compare_field("key_value", want.key_value, got.key_value);
            compare_field("packet_length", 8'(want.packet_length), 8'(got.packet_length));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   sent;
    int   stall_cycles;

    bkpf_stream_if #(.item_t(bkpf_pkg::byte_item_t))   byte_ch ();
    bkpf_stream_if #(.item_t(bkpf_pkg::result_item_t)) result_ch ();

    framer_scoreboard sb = new();

    braille_key_packet_framer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.payload);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.payload);
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("braille_key_packet_framer_top test failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic gap);
        bkpf_pkg::byte_item_t it;
        it.data_byte = b;
        it.gap = gap;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.payload <= it;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_gap();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] key_opener();
        case ($urandom_range(0, 2))
            0: return bkpf_pkg::KEY_NAV;
            1: return bkpf_pkg::KEY_SIM;
            default: return bkpf_pkg::KEY_ROUTE;
        endcase
    endfunction

    function automatic logic [7:0] ident_filler();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == bkpf_pkg::IDENT_END)
            b = 8'h41;
        return b;
    endfunction

    // byte expected at position i of a well-formed packet
    function automatic logic [7:0] proper_byte(bit ident, int i, logic [7:0] opener);
        if (ident)
        begin
            case (i)
                0: return bkpf_pkg::IDENT_P;
                1: return bkpf_pkg::IDENT_B;
                2: return bkpf_pkg::IDENT_C;
                default: return ident_filler();
            endcase
        end
        case (i)
            0, 1: return opener;
            2: return 8'($urandom_range(0, 255));
            default: return bkpf_pkg::KEY_END;
        endcase
    endfunction

    task automatic send_broken_packet(input bit ident);
        logic [7:0] opener;
        int cut;
        opener = key_opener();
        cut = ident ? $urandom_range(1, 6) : $urandom_range(1, 4);
        for (int i = 0; i < cut; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(proper_byte(ident, i, opener));
        end
        if ($urandom_range(0, 1) == 0)
            send_gap();
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_ident_packet();
        int fill;
        // now and then a packet that runs to the full length with no end mark
        fill = ($urandom_range(0, 7) == 0) ? int'(bkpf_pkg::IDENT_MAX) - 3
                                           : $urandom_range(0, 8);
        send_byte(bkpf_pkg::IDENT_P);
        send_byte(bkpf_pkg::IDENT_B);
        send_byte(bkpf_pkg::IDENT_C);
        for (int i = 0; i < fill; i++)
            send_byte(ident_filler());
        if (fill < int'(bkpf_pkg::IDENT_MAX) - 3)
            send_byte(bkpf_pkg::IDENT_END);
    endtask

    task automatic send_random_burst();
        logic [7:0] opener;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            opener = key_opener();
            send_byte(opener);
            send_byte(opener);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(bkpf_pkg::KEY_END);
        end
        else if (pick < 58)
            send_ident_packet();
        else if (pick < 73)
            send_broken_packet(1'b0);
        else if (pick < 83)
            send_broken_packet(1'b1);
        else if (pick < 91)
            send_gap();
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_directed();
        send_gap();
        send_byte(8'h00);
        send_byte(bkpf_pkg::KEY_NAV);
        send_byte(bkpf_pkg::KEY_NAV);
        send_byte(8'h5A);
        send_byte(bkpf_pkg::KEY_END);
        send_byte(bkpf_pkg::KEY_SIM);
        send_byte(bkpf_pkg::KEY_SIM);
        send_byte(8'hFF);
        send_byte(bkpf_pkg::KEY_END);
        // bad repeat byte restarts, then a bad end byte restarts again
        send_byte(bkpf_pkg::KEY_NAV);
        send_byte(bkpf_pkg::KEY_SIM);
        send_byte(bkpf_pkg::KEY_SIM);
        send_byte(8'h7E);
        send_byte(bkpf_pkg::KEY_ROUTE);
        send_gap();
        send_byte(bkpf_pkg::IDENT_P);
        send_byte(bkpf_pkg::IDENT_B);
        send_byte(bkpf_pkg::IDENT_C);
        send_byte(bkpf_pkg::IDENT_END);
        send_byte(bkpf_pkg::IDENT_P);
        send_byte(bkpf_pkg::IDENT_END);
        send_byte(bkpf_pkg::IDENT_P);
        send_byte(bkpf_pkg::IDENT_B);
        send_byte(bkpf_pkg::IDENT_C);
        send_byte(bkpf_pkg::IDENT_P);
        send_gap();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sent = 0;
        src_idle_pct = 10;
        sink_idle_pct = 88;
        byte_ch.valid <= 1'b0;
        byte_ch.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                src_idle_pct = 88;
                sink_idle_pct = 10;
            end
            else if (phase == 2)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
                send_random_burst();
        end
        byte_ch.valid <= 1'b0;

        while (sb.framed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.framed_results.size() == 0)
            $display("braille_key_packet_framer_top test passed");
        else
            $display("braille_key_packet_framer_top test failed");
        $finish;
    end

endmodule
